// ===== hdl/maze_wall_map_store_unit_defines.svh =====
// Assertion macros for the checker file.
`ifndef MAZE_WALL_MAP_STORE_UNIT_DEFINES_SVH
`define MAZE_WALL_MAP_STORE_UNIT_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define MWM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("maze map check failed");

// Clocked property that also holds across reset.
`define MWM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("maze map reset check failed");

`endif

// ===== hdl/mwm_pkg.sv =====
`default_nettype none
package mwm_pkg;

  // Operation codes
  localparam logic [2:0] FUNC_SENSE = 3'd0;
  localparam logic [2:0] FUNC_QUERY = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  // Directions, clockwise
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // One map word per cell: wall above, wall to the right, explored, value
  typedef struct packed {
    logic       nwall;
    logic       ewall;
    logic       expl;
    logic [7:0] value;
  } cell_word_t;

  localparam cell_word_t CELL0_RST = '{nwall: 1'b0, ewall: 1'b1, expl: 1'b1, value: 8'd0};

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] heading;
    logic       front;
    logic       left;
    logic       right;
    logic       allow;
    logic [7:0] wval;
  } mwm_req_t;

  // Cell sits on the maze edge in each direction
  typedef struct packed {
    logic top;
    logic right;
    logic bottom;
    logic left;
  } mwm_brd_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
    logic       ign;
  } mwm_res_t;

  typedef struct packed {
    logic       c_en;
    logic       s_en;
    logic       w_en;
    cell_word_t c_word;
    cell_word_t s_word;
    cell_word_t w_word;
  } mwm_wr_t;

endpackage
`default_nettype wire

// ===== hdl/mwm_op_eval.sv =====
`default_nettype none
module mwm_op_eval
  import mwm_pkg::*;
(
  input  logic       active,
  input  mwm_req_t   req,
  input  mwm_brd_t   brd,
  input  cell_word_t c_word,
  input  cell_word_t n_word,
  input  cell_word_t e_word,
  input  cell_word_t s_word,
  input  cell_word_t w_word,
  output mwm_res_t   res,
  output mwm_wr_t    wr
);

  logic [3:0] border_v;
  logic [3:0] expl_v;
  logic [3:0] wall_v;
  logic [3:0] sensed_v;
  logic [3:0] set_v;
  logic [1:0] behind;
  logic [7:0] nbr_val;

  always_comb begin
    border_v[DIR_UP]    = brd.top;
    border_v[DIR_RIGHT] = brd.right;
    border_v[DIR_DOWN]  = brd.bottom;
    border_v[DIR_LEFT]  = brd.left;

    expl_v[DIR_UP]    = n_word.expl;
    expl_v[DIR_RIGHT] = e_word.expl;
    expl_v[DIR_DOWN]  = s_word.expl;
    expl_v[DIR_LEFT]  = w_word.expl;

    // Border always reads as a wall
    wall_v[DIR_UP]    = brd.top    | c_word.nwall;
    wall_v[DIR_RIGHT] = brd.right  | c_word.ewall;
    wall_v[DIR_DOWN]  = brd.bottom | s_word.nwall;
    wall_v[DIR_LEFT]  = brd.left   | w_word.ewall;

    // Map robot-relative sensors onto absolute directions
    sensed_v = 4'b0000;
    sensed_v[req.heading]        = req.front;
    sensed_v[req.heading + 2'd1] = req.right;
    sensed_v[req.heading + 2'd3] = req.left;
    behind = req.heading + 2'd2;

    case (req.heading)
      DIR_UP:    nbr_val = n_word.value;
      DIR_RIGHT: nbr_val = e_word.value;
      DIR_DOWN:  nbr_val = s_word.value;
      default:   nbr_val = w_word.value;
    endcase
  end

  always_comb begin
    res       = '0;
    wr        = '0;
    wr.c_word = c_word;
    wr.s_word = s_word;
    wr.w_word = w_word;
    set_v     = 4'b0000;
    if (active) begin
      unique case (req.func)
        FUNC_SENSE: begin
          if (wall_v[behind]) begin
            res.ign = 1'b1;
          end else begin
            // no wall next to an explored cell, none on the border
            set_v = sensed_v & ~border_v & ~expl_v & {4{~c_word.expl}};
            wr.c_en         = 1'b1;
            wr.c_word.nwall = c_word.nwall | set_v[DIR_UP];
            wr.c_word.ewall = c_word.ewall | set_v[DIR_RIGHT];
            wr.c_word.expl  = 1'b1;
            wr.s_en         = set_v[DIR_DOWN];
            wr.s_word.nwall = 1'b1;
            wr.w_en         = set_v[DIR_LEFT];
            wr.w_word.ewall = 1'b1;
          end
        end
        FUNC_QUERY: begin
          if (!wall_v[req.heading] && (expl_v[req.heading] || req.allow)) begin
            res.ok  = 1'b1;
            res.val = nbr_val;
          end
        end
        FUNC_WRITE: begin
          wr.c_en         = 1'b1;
          wr.c_word.value = req.wval;
        end
        FUNC_READ: begin
          res.val = c_word.value;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/maze_wall_map_store_unit.sv =====
`default_nettype none
// Maze wall map store: one map word per cell (wall above, wall to the right,
// explored flag, 8-bit value) in a single synchronous RAM with one write and
// one registered read port. Each transfer runs a fixed read-modify-write
// sequence: five reads (the cell and its four neighbors, one per cycle,
// through the registered read port), three write slots (the cell, the cell
// below, the cell to the left), then the result is placed in the output
// register and in_ready returns. An item with a coordinate outside the maze
// or an unused func code skips the reads and writes and goes straight to
// placing its result. Items are handled one at a time; a waiting result
// does not block the sequencer until it has a new result to deliver, and
// then the sequencer holds until the output register is free.
// After reset, and for a clear item, the unit sweeps the RAM one cell per
// cycle over all MAZE_SIDE*MAZE_SIDE cells (256 at the default size), with
// in_ready low; a clear item's all-zero result follows the sweep.
module maze_wall_map_store_unit
  import mwm_pkg::*;
#(
  parameter int MAZE_SIDE = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_func,
  input  wire logic [3:0] in_pos_x,
  input  wire logic [3:0] in_pos_y,
  input  wire logic [1:0] in_heading,
  input  wire logic       in_sensed_front,
  input  wire logic       in_sensed_left,
  input  wire logic       in_sensed_right,
  input  wire logic       in_allow_unexplored,
  input  wire logic [7:0] in_write_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_neighbor_ok,
  output logic [7:0]      out_cell_value,
  output logic            out_sense_ignored
);

  localparam int MAP_CELLS = MAZE_SIDE * MAZE_SIDE;
  localparam int IDX_W     = $clog2(MAP_CELLS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [2:0] SLOT_READ_LAST  = 3'd5;
  localparam logic [2:0] SLOT_WRITE_LAST = 3'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAP_CELLS - 1);
  localparam logic [IDX_W-1:0] IDX_ROW  = IDX_W'(MAZE_SIDE);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // Map RAM
  cell_word_t mem_r [MAP_CELLS];
  cell_word_t rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  cell_word_t       mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem_r[mem_raddr];
  end

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [2:0]       slot_r, slot_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             clr_emit_r, clr_emit_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Item context, loaded on transfer
  mwm_req_t         req_r;
  mwm_brd_t         brd_r;
  logic             active_r;
  logic [IDX_W-1:0] cidx_r, nidx_r, eidx_r, sidx_r, widx_r;
  cell_word_t       c_word_r, n_word_r, e_word_r, s_word_r, w_word_r;

  logic             out_neighbor_ok_r;
  logic [7:0]       out_cell_value_r;
  logic             out_sense_ignored_r;

  // Decode of the incoming item
  logic             in_xfer;
  logic             in_range;
  logic             active_in;
  mwm_brd_t         brd_in;
  mwm_req_t         req_in;
  logic [IDX_W-1:0] cidx_in;
  logic             res_load;

  mwm_res_t res;
  mwm_wr_t  wr;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_neighbor_ok   = out_neighbor_ok_r;
  assign out_cell_value    = out_cell_value_r;
  assign out_sense_ignored = out_sense_ignored_r;

  always_comb begin
    in_range  = (32'(in_pos_x) < MAZE_SIDE) && (32'(in_pos_y) < MAZE_SIDE);
    active_in = in_range && ((in_func == FUNC_SENSE) || (in_func == FUNC_QUERY) ||
                             (in_func == FUNC_WRITE) || (in_func == FUNC_READ));
    brd_in.top    = (32'(in_pos_y) == MAZE_SIDE - 1);
    brd_in.right  = (32'(in_pos_x) == MAZE_SIDE - 1);
    brd_in.bottom = (in_pos_y == 4'd0);
    brd_in.left   = (in_pos_x == 4'd0);
    // Hold index at zero for coordinates outside the maze
    cidx_in = in_range ? IDX_W'(32'(in_pos_y) * MAZE_SIDE + 32'(in_pos_x))
                       : '0;
    req_in.func    = in_func;
    req_in.heading = in_heading;
    req_in.front   = in_sensed_front;
    req_in.left    = in_sensed_left;
    req_in.right   = in_sensed_right;
    req_in.allow   = in_allow_unexplored;
    req_in.wval    = in_write_value;
  end

  mwm_op_eval u_eval (
    .active (active_r),
    .req    (req_r),
    .brd    (brd_r),
    .c_word (c_word_r),
    .n_word (n_word_r),
    .e_word (e_word_r),
    .s_word (s_word_r),
    .w_word (w_word_r),
    .res    (res),
    .wr     (wr)
  );

  // RAM port muxing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = '0;
    mem_raddr = cidx_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (clr_idx_r == '0) ? CELL0_RST : '0;
      end
      ST_READ: begin
        case (slot_r)
          3'd0:    mem_raddr = cidx_r;
          3'd1:    mem_raddr = nidx_r;
          3'd2:    mem_raddr = eidx_r;
          3'd3:    mem_raddr = sidx_r;
          3'd4:    mem_raddr = widx_r;
          default: mem_raddr = cidx_r;
        endcase
      end
      ST_WRITE: begin
        case (slot_r)
          3'd0: begin
            mem_we    = wr.c_en;
            mem_waddr = cidx_r;
            mem_wdata = wr.c_word;
          end
          3'd1: begin
            mem_we    = wr.s_en;
            mem_waddr = sidx_r;
            mem_wdata = wr.s_word;
          end
          default: begin
            mem_we    = wr.w_en;
            mem_waddr = widx_r;
            mem_wdata = wr.w_word;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    clr_idx_nxt  = clr_idx_r;
    clr_emit_nxt = clr_emit_r;
    res_load     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IDX_ONE;
        if (clr_idx_r == IDX_LAST) begin
          clr_idx_nxt  = '0;
          clr_emit_nxt = 1'b0;
          state_nxt    = clr_emit_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          slot_nxt = 3'd0;
          if (in_func == FUNC_CLEAR) begin
            clr_idx_nxt  = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = ST_CLEAR;
          end else if (active_in) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        slot_nxt = slot_r + 3'd1;
        if (slot_r == SLOT_READ_LAST) begin
          slot_nxt  = 3'd0;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        slot_nxt = slot_r + 3'd1;
        if (slot_r == SLOT_WRITE_LAST) begin
          slot_nxt  = 3'd0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || res_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      slot_r      <= 3'd0;
      clr_idx_r   <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item context and read capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r    <= req_in;
      brd_r    <= brd_in;
      active_r <= active_in;
      cidx_r   <= cidx_in;
      // Neighbors off the edge fall back to the cell itself
      nidx_r   <= brd_in.top    ? cidx_in : cidx_in + IDX_ROW;
      eidx_r   <= brd_in.right  ? cidx_in : cidx_in + IDX_ONE;
      sidx_r   <= brd_in.bottom ? cidx_in : cidx_in - IDX_ROW;
      widx_r   <= brd_in.left   ? cidx_in : cidx_in - IDX_ONE;
    end
    if (state_r == ST_READ) begin
      case (slot_r)
        3'd1:    c_word_r <= rdata_r;
        3'd2:    n_word_r <= rdata_r;
        3'd3:    e_word_r <= rdata_r;
        3'd4:    s_word_r <= rdata_r;
        3'd5:    w_word_r <= rdata_r;
        default: begin
        end
      endcase
    end
    if (res_load) begin
      out_neighbor_ok_r   <= res.ok;
      out_cell_value_r    <= res.val;
      out_sense_ignored_r <= res.ign;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mwm_checker.sv =====
`default_nettype none
`include "maze_wall_map_store_unit_defines.svh"
module mwm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_func,
  input wire logic [3:0] in_pos_x,
  input wire logic [3:0] in_pos_y,
  input wire logic [1:0] in_heading,
  input wire logic       in_sensed_front,
  input wire logic       in_sensed_left,
  input wire logic       in_sensed_right,
  input wire logic       in_allow_unexplored,
  input wire logic [7:0] in_write_value,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_neighbor_ok,
  input wire logic [7:0] out_cell_value,
  input wire logic       out_sense_ignored
);

  // Stalled result holds its payload
  `MWM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_cell_value) && $stable(out_neighbor_ok) && $stable(out_sense_ignored))

  // One item at a time: busy right after a transfer
  `MWM_ASSERT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // Query success and sense skip come from different operations
  `MWM_ASSERT(a_ok_ign_excl, clk, rst_n, out_valid |-> !(out_neighbor_ok && out_sense_ignored))

  // Reset empties the output and starts the clearing sweep
  `MWM_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_valid && !in_ready)

endmodule

bind maze_wall_map_store_unit mwm_checker u_mwm_checker (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import mwm_pkg::*;

  localparam int SIDE = 16;
  localparam int RANDOM_OPS = 1500;

  // Func codes the block treats as no-ops
  localparam logic [2:0] FUNC_SPARE5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  // One map operation as driven on the input channel
  typedef struct {
    logic [2:0] func;
    logic [3:0] x;
    logic [3:0] y;
    logic [1:0] hd;
    logic       front;
    logic       left;
    logic       right;
    logic       allow;
    logic [7:0] wval;
  } map_op_t;

  // Directed row: the operation plus, where obvious, the result typed in
  typedef struct {
    map_op_t  op;
    bit       typed;
    mwm_res_t res;
  } map_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_func;
  logic [3:0] in_pos_x;
  logic [3:0] in_pos_y;
  logic [1:0] in_heading;
  logic       in_sensed_front;
  logic       in_sensed_left;
  logic       in_sensed_right;
  logic       in_allow_unexplored;
  logic [7:0] in_write_value;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_neighbor_ok;
  logic [7:0] out_cell_value;
  logic       out_sense_ignored;

  // Shadow copy of the maze map
  bit         north_w [SIDE*(SIDE-1)];
  bit         east_w  [SIDE*(SIDE-1)];
  bit         seen    [SIDE*SIDE];
  logic [7:0] val_mem [SIDE*SIDE];

  mwm_res_t   pending_res_q[$];   // results owed by the block, oldest first
  map_row_t   plan_q[$];          // directed stimulus table
  int         err_count = 0;
  bit         gaps_on = 1'b1;     // random idling on both channels

  maze_wall_map_store_unit #(.MAZE_SIDE(SIDE)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_heading          (in_heading),
    .in_sensed_front     (in_sensed_front),
    .in_sensed_left      (in_sensed_left),
    .in_sensed_right     (in_sensed_right),
    .in_allow_unexplored (in_allow_unexplored),
    .in_write_value      (in_write_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_neighbor_ok     (out_neighbor_ok),
    .out_cell_value      (out_cell_value),
    .out_sense_ignored   (out_sense_ignored)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The border is always a wall and is never stored
  function automatic bit at_edge(logic [1:0] dir, int x, int y);
    return (dir == DIR_LEFT && x == 0) || (dir == DIR_RIGHT && x == SIDE-1) ||
           (dir == DIR_DOWN && y == 0) || (dir == DIR_UP && y == SIDE-1);
  endfunction

  function automatic bit wall_is_set(logic [1:0] dir, int x, int y);
    if (at_edge(dir, x, y)) return 1'b1;
    // Fold left/down onto the right/up wall of the neighbor
    if (dir == DIR_LEFT) begin
      x = x - 1;
      dir = DIR_RIGHT;
    end
    if (dir == DIR_DOWN) begin
      y = y - 1;
      dir = DIR_UP;
    end
    if (dir == DIR_RIGHT) return east_w[x*SIDE + y];
    return north_w[y*SIDE + x];
  endfunction

  // Set a wall unless it is on the border or touches an explored cell
  function automatic void wall_mark(logic [1:0] dir, int x, int y);
    int bx;
    int by;
    if (at_edge(dir, x, y)) return;
    if (dir == DIR_LEFT) begin
      x = x - 1;
      dir = DIR_RIGHT;
    end
    if (dir == DIR_DOWN) begin
      y = y - 1;
      dir = DIR_UP;
    end
    bx = (dir == DIR_RIGHT) ? x + 1 : x;
    by = (dir == DIR_UP) ? y + 1 : y;
    if (seen[y*SIDE + x] || seen[by*SIDE + bx]) return;
    if (dir == DIR_RIGHT) east_w[x*SIDE + y] = 1'b1;
    else north_w[y*SIDE + x] = 1'b1;
  endfunction

  function automatic void map_reset();
    foreach (north_w[i]) north_w[i] = 1'b0;
    foreach (east_w[i]) east_w[i] = 1'b0;
    foreach (seen[i]) seen[i] = 1'b0;
    foreach (val_mem[i]) val_mem[i] = 8'd0;
    wall_mark(DIR_RIGHT, 0, 0);
    seen[0] = 1'b1;
  endfunction

  // Apply one operation to the shadow map and return the result it owes
  function automatic mwm_res_t map_step(map_op_t op);
    mwm_res_t r;
    int       nx;
    int       ny;
    r = '0;
    nx = op.x;
    ny = op.y;
    if (op.func == FUNC_CLEAR) begin
      map_reset();
    end else if (op.x < SIDE && op.y < SIDE) begin
      case (op.func)
        FUNC_SENSE: begin
          if (wall_is_set(2'(op.hd + 2'd2), op.x, op.y)) begin
            r.ign = 1'b1;
          end else begin
            if (op.front) wall_mark(op.hd, op.x, op.y);
            if (op.left) wall_mark(2'(op.hd + 2'd3), op.x, op.y);
            if (op.right) wall_mark(2'(op.hd + 2'd1), op.x, op.y);
            seen[op.y*SIDE + op.x] = 1'b1;
          end
        end
        FUNC_QUERY: begin
          if (!wall_is_set(op.hd, op.x, op.y)) begin
            case (op.hd)
              DIR_UP:    ny = ny + 1;
              DIR_RIGHT: nx = nx + 1;
              DIR_DOWN:  ny = ny - 1;
              default:   nx = nx - 1;
            endcase
            if (seen[ny*SIDE + nx] || op.allow) begin
              r.ok = 1'b1;
              r.val = val_mem[ny*SIDE + nx];
            end
          end
        end
        FUNC_WRITE: val_mem[op.y*SIDE + op.x] = op.wval;
        FUNC_READ:  r.val = val_mem[op.y*SIDE + op.x];
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic map_row_t mk_row(logic [2:0] func, int x, int y, logic [1:0] hd,
                                      bit f, bit l, bit rt, bit allow, logic [7:0] wval,
                                      bit typed, bit ok, logic [7:0] val, bit ign);
    map_row_t row;
    row.op = '{func: func, x: 4'(x), y: 4'(y), hd: hd, front: f, left: l,
               right: rt, allow: allow, wval: wval};
    row.typed = typed;
    row.res = '{ok: ok, val: val, ign: ign};
    return row;
  endfunction

  // Drive one operation, hold it until the transfer, then log what it owes.
  // Valid stays high afterwards so a back-to-back op can follow without a gap.
  task automatic issue_op(input map_op_t op, input bit typed, input mwm_res_t typed_res,
                          output mwm_res_t pred);
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_func             <= op.func;
    in_pos_x            <= op.x;
    in_pos_y            <= op.y;
    in_heading          <= op.hd;
    in_sensed_front     <= op.front;
    in_sensed_left      <= op.left;
    in_sensed_right     <= op.right;
    in_allow_unexplored <= op.allow;
    in_write_value      <= op.wval;
    do @(posedge clk); while (!in_ready);
    pred = map_step(op);
    pending_res_q.push_back(typed ? typed_res : pred);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_res_q.size() != 0);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    err_count++;
    $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  // Result side: stall at random while gaps are on, and check each transfer
  // against the oldest owed result. Values read here are the ones present at the edge.
  always @(posedge clk) begin
    mwm_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_res_q.size() == 0) begin
        note_mismatch("result with nothing owed, cell_value", -1, out_cell_value);
      end else begin
        want = pending_res_q.pop_front();
        if (out_neighbor_ok !== want.ok)
          note_mismatch("neighbor_ok", want.ok, out_neighbor_ok);
        if (out_cell_value !== want.val)
          note_mismatch("cell_value", want.val, out_cell_value);
        if (out_sense_ignored !== want.ign)
          note_mismatch("sense_ignored", want.ign, out_sense_ignored);
      end
    end
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= 17) : 1'b1;
  end

  initial begin
    map_op_t  op;
    mwm_res_t pred;
    mwm_res_t nil_res;
    int       roll;
    int       rx;
    int       ry;
    logic [1:0] rhd;
    bit       sense_next;
    bit       walk_query;

    nil_res = '0;
    rx = 0;
    ry = 0;
    rhd = DIR_UP;
    sense_next = 1'b1;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_func             = FUNC_READ;
    in_pos_x            = 4'd0;
    in_pos_y            = 4'd0;
    in_heading          = DIR_UP;
    in_sensed_front     = 1'b0;
    in_sensed_left      = 1'b0;
    in_sensed_right     = 1'b0;
    in_allow_unexplored = 1'b0;
    in_write_value      = 8'd0;
    map_reset();

    // Directed table. Typed rows are plain to see from the reset map; the
    // others depend on earlier rows and go through the shadow map.
    //                func        x   y   hd         f  l  r  al wval  typed ok val ign
    // reset map: east wall of the corner cell, border on two sides
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  0, DIR_RIGHT, 0, 0, 0, 0, 8'h00, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  0, DIR_UP,    0, 0, 0, 1, 8'h00, 1, 1, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  0, DIR_DOWN,  0, 0, 0, 1, 8'h00, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  0, DIR_LEFT,  1, 1, 1, 1, 8'hFF, 1, 0, 8'h00, 0));
    // border behind the robot: sense skipped
    plan_q.push_back(mk_row(FUNC_SENSE,  0,  0, DIR_UP,    1, 1, 1, 0, 8'h00, 1, 0, 8'h00, 1));
    plan_q.push_back(mk_row(FUNC_SENSE, 15, 15, DIR_DOWN,  1, 1, 1, 1, 8'hFF, 1, 0, 8'h00, 1));
    plan_q.push_back(mk_row(FUNC_SENSE, 15, 15, DIR_LEFT,  0, 0, 0, 0, 8'h00, 1, 0, 8'h00, 1));
    // real sense on a fresh cell, then look through the walls it set
    plan_q.push_back(mk_row(FUNC_SENSE,  0,  1, DIR_UP,    1, 1, 1, 0, 8'h00, 0, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  1, DIR_UP,    0, 0, 0, 1, 8'h00, 0, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  0, DIR_UP,    0, 0, 0, 0, 8'h00, 0, 0, 8'h00, 0));
    // stored wall behind the robot
    plan_q.push_back(mk_row(FUNC_SENSE,  1,  1, DIR_RIGHT, 1, 1, 1, 0, 8'h00, 0, 0, 8'h00, 0));
    // value store at the extremes
    plan_q.push_back(mk_row(FUNC_WRITE, 15, 15, DIR_LEFT,  1, 1, 1, 1, 8'hFF, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_WRITE,  0,  1, DIR_UP,    0, 0, 0, 0, 8'hA5, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_READ,  15, 15, DIR_UP,    0, 0, 0, 0, 8'h00, 1, 0, 8'hFF, 0));
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  0, DIR_UP,    0, 0, 0, 0, 8'h00, 0, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_WRITE, 15,  0, DIR_DOWN,  0, 0, 0, 0, 8'h01, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY, 14,  0, DIR_RIGHT, 0, 0, 0, 1, 8'h00, 0, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY, 14,  0, DIR_RIGHT, 0, 0, 0, 0, 8'h00, 0, 0, 8'h00, 0));
    // unused func codes: no-op, zero result
    plan_q.push_back(mk_row(FUNC_SPARE5, 15, 15, DIR_LEFT, 1, 1, 1, 1, 8'hFF, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_SPARE6,  0,  0, DIR_UP,   0, 0, 0, 0, 8'h00, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_SPARE7, 15, 15, DIR_LEFT, 1, 1, 1, 1, 8'hFF, 1, 0, 8'h00, 0));
    // clear brings back the reset map
    plan_q.push_back(mk_row(FUNC_CLEAR, 15, 15, DIR_LEFT,  1, 1, 1, 1, 8'hFF, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_READ,  15, 15, DIR_UP,    0, 0, 0, 0, 8'h00, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_QUERY,  0,  0, DIR_RIGHT, 0, 0, 0, 1, 8'h00, 1, 0, 8'h00, 0));
    plan_q.push_back(mk_row(FUNC_SENSE,  0,  1, DIR_UP,    0, 0, 0, 0, 8'h00, 0, 0, 8'h00, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The block sweeps its RAM after reset; the handshake absorbs that
    foreach (plan_q[i]) issue_op(plan_q[i].op, plan_q[i].typed, plan_q[i].res, pred);
    drain_results();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      // Long stretch with no random idling on either side
      gaps_on = !(n >= 400 && n < 700);
      if (n == 900) drain_results();

      op.func  = FUNC_READ;
      op.x     = 4'($urandom_range(0, SIDE-1));
      op.y     = 4'($urandom_range(0, SIDE-1));
      op.hd    = 2'($urandom_range(0, 3));
      op.front = 1'($urandom_range(0, 1));
      op.left  = 1'($urandom_range(0, 1));
      op.right = 1'($urandom_range(0, 1));
      op.allow = 1'($urandom_range(0, 1));
      op.wval  = 8'($urandom_range(0, 255));
      walk_query = 1'b0;
      roll = $urandom_range(0, 99);

      if (roll < 2) begin
        op.func = FUNC_CLEAR;
      end else if (roll < 4) begin
        op.func = 3'($urandom_range(FUNC_SPARE5, FUNC_SPARE7));
      end else if (roll < 14) begin
        op.func = FUNC_WRITE;
      end else if (roll < 24) begin
        op.func = FUNC_READ;
      end else if (roll < 30) begin
        op.func = FUNC_SENSE;
      end else if (roll < 40) begin
        op.func = FUNC_QUERY;
      end else begin
        // Robot walk: sense where it stands, then probe a direction and
        // advance when the way is open. Jump elsewhere now and then.
        if ($urandom_range(0, 19) == 0) begin
          rx  = $urandom_range(0, SIDE-1);
          ry  = $urandom_range(0, SIDE-1);
          rhd = 2'($urandom_range(0, 3));
        end
        op.x = 4'(rx);
        op.y = 4'(ry);
        if (sense_next) begin
          op.func  = FUNC_SENSE;
          op.hd    = rhd;
          op.front = ($urandom_range(0, 9) < 3);
          op.left  = ($urandom_range(0, 9) < 3);
          op.right = ($urandom_range(0, 9) < 3);
        end else if ($urandom_range(0, 9) == 0) begin
          op.func = FUNC_WRITE;
        end else begin
          op.func = FUNC_QUERY;
          walk_query = 1'b1;
        end
        sense_next = !sense_next;
      end

      issue_op(op, 1'b0, nil_res, pred);

      if (walk_query && pred.ok) begin
        case (op.hd)
          DIR_UP:    ry = ry + 1;
          DIR_RIGHT: rx = rx + 1;
          DIR_DOWN:  ry = ry - 1;
          default:   rx = rx - 1;
        endcase
        rhd = op.hd;
      end
    end

    drain_results();
    // Catch any stray result after the last one owed
    repeat (30) @(posedge clk);

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
